>>> hw/rtl/pcyc_pkg.sv
// Shared types and constants for the palette range cycler.
// Used by pcyc_cell and palette_range_cycler_core; no dependencies.
`default_nettype none
package pcyc_pkg;

  localparam int ColorW = 12;
  localparam int BoundW = 6;
  localparam int RateW  = 15;
  localparam int MaxBurst = 64;

  // Command codes of an input word
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_COLOR = 2'd1;
  localparam logic [1:0] CMD_RANGE = 2'd2;
  localparam logic [1:0] CMD_MODE  = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_RESTORE,
    CELL_ROT_FWD,
    CELL_ROT_REV
  } cell_op_e;

  // Broadcast control to every cell of the palette row
  typedef struct packed {
    cell_op_e            op;
    logic [BoundW-1:0]   slot;
    logic [ColorW-1:0]   data;
    logic [BoundW-1:0]   lo;
    logic [BoundW-1:0]   hi;
    logic [ColorW-1:0]   wrap;
    logic [6:0]          count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/pcyc_cell.sv
// One palette entry: working and saved colour, shifting to its neighbours.
// Depends on pcyc_pkg.
`default_nettype none
module pcyc_cell #(
  parameter int Idx = 0
) (
  input  logic                      clk_i,
  input  pcyc_pkg::cell_ctrl_t      ctrl_i,
  input  logic [pcyc_pkg::ColorW-1:0] left_i,
  input  logic [pcyc_pkg::ColorW-1:0] right_i,
  output logic [pcyc_pkg::ColorW-1:0] work_o,
  output logic [pcyc_pkg::ColorW-1:0] saved_o
);
  import pcyc_pkg::*;

  logic [ColorW-1:0] work_q, work_d, saved_q, saved_d;
  int lo, hi, sl, cnt;

  // Pick next colours from the broadcast operation
  always_comb begin
    lo = int'(ctrl_i.lo);
    hi = int'(ctrl_i.hi);
    sl = int'(ctrl_i.slot);
    cnt = int'(ctrl_i.count);
    work_d = work_q;
    saved_d = saved_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        if (sl == Idx) begin
          work_d = ctrl_i.data;
          saved_d = ctrl_i.data;
        end
      end
      CELL_RESTORE: begin
        if (Idx < cnt) work_d = saved_q;
      end
      CELL_ROT_FWD: begin
        if (Idx == lo) work_d = ctrl_i.wrap;
        else if (Idx > lo && Idx <= hi) work_d = left_i;
      end
      CELL_ROT_REV: begin
        if (Idx == hi) work_d = ctrl_i.wrap;
        else if (Idx >= lo && Idx < hi) work_d = right_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    saved_q <= saved_d;
  end

  assign work_o = work_q;
  assign saved_o = saved_q;

endmodule
`default_nettype wire

>>> hw/rtl/palette_range_cycler_core.sv
// Channel  | handshake                  | payload
// in       | in_valid_i / in_ready_o    | command_i slot_i color_i range_* rate_i flags
// out      | out_valid_o / out_ready_i  | palette_index_o palette_color_o last_o
// cfg      | cfg_we_i                   | cfg_idx_i cfg_wdata_i
// Load and mode words are taken in the idle state. A tick in cycle mode passes
// through a restore step on leaving wait, then walks the ranges in turn (the walk
// rotates the cell row at most once per range), then emits a burst if any rotated.
// Reset clears counters, mode and the control state; palettes and ranges are
// undefined until loaded. Output stalls hold the burst; no input is taken then.
// Top level of the palette range cycler; depends on pcyc_pkg and pcyc_cell.
`default_nettype none
module palette_range_cycler_core #(
  parameter int PALETTE_SIZE = 64,
  parameter int MAX_RANGES   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  slot_i,
  input  logic [11:0] color_i,
  input  logic [5:0]  range_low_i,
  input  logic [5:0]  range_high_i,
  input  logic [14:0] rate_i,
  input  logic        active_i,
  input  logic        reverse_i,
  input  logic        cycle_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  palette_index_o,
  output logic [11:0] palette_color_o,
  output logic        last_o
);
  import pcyc_pkg::*;

  localparam int PIW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int RW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int Lim = (PALETTE_SIZE < MaxBurst) ? PALETTE_SIZE : MaxBurst;

  typedef enum logic [1:0] {S_IDLE, S_RESTORE, S_WALK, S_EMIT} state_e;

  state_e state_q;
  logic [6:0] cc_q;
  logic [4:0] rc_q;
  logic mode_q, waiting_q, clr_q, any_q, saved_sel_q;
  logic [RW-1:0] r_q;
  logic [5:0] e_q;
  logic out_valid_q, last_q;
  logic [5:0] idx_q;
  logic [ColorW-1:0] col_q;

  logic [BoundW-1:0] lows_q [MAX_RANGES];
  logic [BoundW-1:0] highs_q [MAX_RANGES];
  logic [RateW-1:0]  rates_q [MAX_RANGES];
  logic [1:0]        flags_q [MAX_RANGES];
  logic [RateW-1:0]  cnt_q [MAX_RANGES];

  logic [ColorW-1:0] work_w [PALETTE_SIZE];
  logic [ColorW-1:0] saved_w [PALETTE_SIZE];
  cell_ctrl_t ctrl;

  logic accept;
  logic [6:0] n_col, n_rng;
  logic [RateW-1:0] cnt_next;
  logic fire, rot, r_last, e_last, out_take;
  logic [PIW-1:0] lo_idx, hi_idx, e_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;

  // Clamp the register values to the usable counts
  always_comb begin
    n_col = (cc_q == 7'd0) ? 7'd1 : cc_q;
    if (int'(n_col) > Lim) n_col = 7'(Lim);
    n_rng = (rc_q == 5'd0) ? 7'd1 : {2'b0, rc_q};
    if (int'(n_rng) > MAX_RANGES) n_rng = 7'(MAX_RANGES);
  end

  // Range step of the walk
  always_comb begin
    cnt_next = (clr_q ? '0 : cnt_q[r_q]) + RateW'(1);
    fire = (rates_q[r_q] != '0) && (cnt_next == rates_q[r_q]);
    rot = fire && flags_q[r_q][0] && (lows_q[r_q] < highs_q[r_q])
          && (int'(highs_q[r_q]) < PALETTE_SIZE);
    r_last = ({1'b0, 6'(r_q)} == n_rng - 7'd1);
    lo_idx = PIW'(lows_q[r_q]);
    hi_idx = PIW'(highs_q[r_q]);
    e_idx = PIW'(e_q);
    e_last = ({1'b0, e_q} == n_col - 7'd1);
    out_take = !out_valid_q || out_ready_i;
  end

  // Broadcast control to the cell row
  always_comb begin
    ctrl.op = CELL_HOLD;
    ctrl.slot = slot_i;
    ctrl.data = color_i;
    ctrl.lo = lows_q[r_q];
    ctrl.hi = highs_q[r_q];
    ctrl.wrap = flags_q[r_q][1] ? work_w[lo_idx] : work_w[hi_idx];
    ctrl.count = n_col;
    if (accept && command_i == CMD_COLOR) ctrl.op = CELL_LOAD;
    else if (state_q == S_RESTORE) ctrl.op = CELL_RESTORE;
    else if (state_q == S_WALK && rot) ctrl.op = flags_q[r_q][1] ? CELL_ROT_REV : CELL_ROT_FWD;
  end

  // Row of palette cells
  for (genvar j = 0; j < PALETTE_SIZE; j++) begin : g_cell
    pcyc_cell #(.Idx(j)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (work_w[(j > 0) ? j - 1 : j]),
      .right_i(work_w[(j < PALETTE_SIZE - 1) ? j + 1 : j]),
      .work_o (work_w[j]),
      .saved_o(saved_w[j])
    );
  end

  // Range table writes
  always_ff @(posedge clk_i) begin
    if (accept && command_i == CMD_RANGE && int'(slot_i) < MAX_RANGES) begin
      lows_q[RW'(slot_i)] <= range_low_i;
      highs_q[RW'(slot_i)] <= range_high_i;
      rates_q[RW'(slot_i)] <= rate_i;
      flags_q[RW'(slot_i)] <= {reverse_i, active_i};
    end
  end

  // Control, counters and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cc_q <= 7'd64;
      rc_q <= 5'd16;
      mode_q <= 1'b0;
      waiting_q <= 1'b1;
      clr_q <= 1'b0;
      any_q <= 1'b0;
      saved_sel_q <= 1'b0;
      r_q <= '0;
      e_q <= '0;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      col_q <= '0;
      last_q <= 1'b0;
      for (int k = 0; k < MAX_RANGES; k++) cnt_q[k] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'b0) cc_q <= cfg_wdata_i;
        else rc_q <= cfg_wdata_i[4:0];
      end
      // Drop the output word once taken; the burst state refills it itself
      if (out_valid_q && out_ready_i && state_q != S_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (command_i)
              CMD_RANGE: begin
                if (int'(slot_i) < MAX_RANGES) cnt_q[RW'(slot_i)] <= '0;
              end
              CMD_MODE: mode_q <= cycle_on_i;
              CMD_TICK: begin
                r_q <= '0;
                e_q <= '0;
                any_q <= 1'b0;
                if (!mode_q) begin
                  if (!waiting_q) begin
                    waiting_q <= 1'b1;
                    saved_sel_q <= 1'b1;
                    state_q <= S_EMIT;
                  end
                end else if (waiting_q) begin
                  waiting_q <= 1'b0;
                  clr_q <= 1'b1;
                  state_q <= S_RESTORE;
                end else begin
                  state_q <= S_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        S_RESTORE: state_q <= S_WALK;
        S_WALK: begin
          cnt_q[r_q] <= fire ? '0 : cnt_next;
          if (rot) any_q <= 1'b1;
          if (r_last) begin
            clr_q <= 1'b0;
            saved_sel_q <= 1'b0;
            state_q <= (any_q || rot) ? S_EMIT : S_IDLE;
          end else begin
            r_q <= r_q + RW'(1);
          end
        end
        S_EMIT: begin
          if (out_take) begin
            out_valid_q <= 1'b1;
            idx_q <= e_q;
            col_q <= saved_sel_q ? saved_w[e_idx] : work_w[e_idx];
            last_q <= e_last;
            e_q <= e_q + 6'd1;
            if (e_last) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign palette_index_o = idx_q;
  assign palette_color_o = col_q;
  assign last_o = last_q;

`ifndef SYNTHESIS
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> int'(r_q) < int'(n_rng)) else $error("range walk overran");
  a_rot_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == CELL_ROT_FWD || ctrl.op == CELL_ROT_REV) |-> state_q == S_WALK)
    else $error("rotation outside range walk");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> int'(e_q) < Lim) else $error("burst index overran");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_take && e_last) |=> state_q == S_IDLE)
    else $error("burst did not end on last word");
`endif

endmodule
`default_nettype wire
